FILE: src/psc_pkg.sv
`timescale 1ns / 1ps

package psc_pkg;

    // Largest packet length in bytes; it sets the saturation point of the bit total.
    localparam longint unsigned MAX_PACKET_BYTES = 64'd16777216;

    localparam int TOTAL_W = 28;
    localparam longint unsigned TOTAL_RAW = MAX_PACKET_BYTES * 64'd8;
    localparam longint unsigned TOTAL_MAX = 64'h0FFF_FFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_BOUND =
        TOTAL_W'((TOTAL_RAW > TOTAL_MAX) ? TOTAL_MAX : TOTAL_RAW);

    // The escape byte that follows two zero bytes.
    localparam logic [7:0] ESC_BYTE = 8'd2;
    localparam logic [3:0] ESC_BITS = 4'd6;
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Everything one input word produces: an optional full byte, then an
    // optional flushed partial byte at the end of a packet.
    typedef struct packed {
        logic               has_full;
        logic [7:0]         full_byte;
        logic               has_part;
        logic [7:0]         part_byte;
        logic [3:0]         part_bits;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } job_t;

endpackage

FILE: src/psc_if.sv
`timescale 1ns / 1ps

// Input channel: one packet byte per word.
interface psc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Output channel: one output byte per word.
interface psc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [3:0]  valid_bits;
    logic        end_of_packet;
    logic [27:0] total_bits;

    modport source (output valid, output out_byte, output valid_bits,
                    output end_of_packet, output total_bits, input ready);
    modport sink (input valid, input out_byte, input valid_bits,
                  input end_of_packet, input total_bits, output ready);
endinterface

FILE: src/psc_front.sv
`timescale 1ns / 1ps

module psc_front (
    input  logic          clk,
    input  logic          rst_n,
    psc_in_if.sink        in_ch,
    input  logic          q_ready,
    output logic          push,
    output psc_pkg::job_t push_job
);
    import psc_pkg::*;

    logic               prev_zero_reg, prev_zero_next;
    logic               prev_prev_zero_reg, prev_prev_zero_next;
    logic [6:0]         pending_bits_reg, pending_bits_next;
    logic [2:0]         pending_count_reg, pending_count_next;
    logic [TOTAL_W-1:0] bit_total_reg, bit_total_next;

    logic               accept;
    logic               escape;
    logic [3:0]         k;
    logic [14:0]        acc;
    logic [3:0]         n;
    logic [2:0]         r;
    logic [6:0]         rem;
    logic [2:0]         rem_n;
    logic [7:0]         full_byte;
    logic [7:0]         part_byte;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] total_sat;

    // A word is taken whenever the queue has room; only words that complete
    // an output byte or end a packet leave a job in the queue.
    assign in_ch.ready = q_ready;
    assign accept = in_ch.valid && q_ready;
    assign push = accept && (push_job.has_full || push_job.has_part);

    // Classify the byte and merge it behind the pending bits.
    always_comb
    begin
        escape = prev_prev_zero_reg && prev_zero_reg && (in_ch.data_byte == ESC_BYTE);
        k = escape ? ESC_BITS : BYTE_BITS;
        acc = escape ? {2'b00, pending_bits_reg, in_ch.data_byte[7:2]}
                     : {pending_bits_reg, in_ch.data_byte};
        n = {1'b0, pending_count_reg} + k;
        r = n[2:0];
        full_byte = 8'(acc >> r);
        if (n >= BYTE_BITS)
        begin
            rem = 7'(acc & ((15'd1 << r) - 15'd1));
            rem_n = r;
        end
        else
        begin
            rem = acc[6:0];
            rem_n = n[2:0];
        end
        part_byte = 8'({1'b0, rem} << (BYTE_BITS - {1'b0, rem_n}));
        sum = {1'b0, bit_total_reg} + (TOTAL_W + 1)'(k);
        total_sat = (sum > {1'b0, TOTAL_BOUND}) ? TOTAL_BOUND : sum[TOTAL_W-1:0];
    end

    // Build the job word for the queue.
    always_comb
    begin
        push_job.has_full = (n >= BYTE_BITS);
        push_job.full_byte = full_byte;
        push_job.has_part = in_ch.last_byte && (rem_n != 3'd0);
        push_job.part_byte = part_byte;
        push_job.part_bits = {1'b0, rem_n};
        push_job.last = in_ch.last_byte;
        push_job.total = total_sat;
    end

    // Next state; the end of a packet clears all history.
    always_comb
    begin
        prev_zero_next = prev_zero_reg;
        prev_prev_zero_next = prev_prev_zero_reg;
        pending_bits_next = pending_bits_reg;
        pending_count_next = pending_count_reg;
        bit_total_next = bit_total_reg;
        if (accept)
        begin
            if (in_ch.last_byte)
            begin
                prev_zero_next = 1'b0;
                prev_prev_zero_next = 1'b0;
                pending_bits_next = '0;
                pending_count_next = '0;
                bit_total_next = '0;
            end
            else
            begin
                prev_prev_zero_next = prev_zero_reg;
                prev_zero_next = (in_ch.data_byte == 8'd0);
                pending_bits_next = rem;
                pending_count_next = rem_n;
                bit_total_next = total_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_zero_reg <= 1'b0;
            prev_prev_zero_reg <= 1'b0;
            pending_bits_reg <= '0;
            pending_count_reg <= '0;
            bit_total_reg <= '0;
        end
        else
        begin
            prev_zero_reg <= prev_zero_next;
            prev_prev_zero_reg <= prev_prev_zero_next;
            pending_bits_reg <= pending_bits_next;
            pending_count_reg <= pending_count_next;
            bit_total_reg <= bit_total_next;
        end
    end

endmodule

FILE: src/psc_queue.sv
`timescale 1ns / 1ps

module psc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  psc_pkg::job_t push_job,
    output logic          not_full,
    input  logic          pop,
    output logic          not_empty,
    output psc_pkg::job_t head_job
);
    import psc_pkg::*;

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign not_full = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Storage for queued jobs.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> not_full)
        else $error("push into full queue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

endmodule

FILE: src/psc_back.sv
`timescale 1ns / 1ps

module psc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          not_empty,
    input  psc_pkg::job_t head_job,
    output logic          pop,
    psc_out_if.source     out_ch
);
    import psc_pkg::*;

    logic               phase_reg, phase_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic [3:0]         valid_bits_reg, valid_bits_next;
    logic               eop_reg, eop_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               load;
    logic               emit_full;

    assign load = not_empty && (!out_valid_reg || out_ch.ready);
    assign emit_full = !phase_reg && head_job.has_full;

    // Pick the next word from the head job: full byte first, then the flush.
    always_comb
    begin
        phase_next = phase_reg;
        pop = 1'b0;
        out_byte_next = out_byte_reg;
        valid_bits_next = valid_bits_reg;
        eop_next = eop_reg;
        total_next = total_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (emit_full)
            begin
                out_byte_next = head_job.full_byte;
                valid_bits_next = BYTE_BITS;
                eop_next = head_job.last && !head_job.has_part;
                total_next = (head_job.last && !head_job.has_part) ? head_job.total : '0;
                pop = !head_job.has_part;
                phase_next = head_job.has_part;
            end
            else
            begin
                out_byte_next = head_job.part_byte;
                valid_bits_next = head_job.part_bits;
                eop_next = 1'b1;
                total_next = head_job.total;
                pop = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        valid_bits_reg <= valid_bits_next;
        eop_reg <= eop_next;
        total_reg <= total_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.valid_bits = valid_bits_reg;
    assign out_ch.end_of_packet = eop_reg;
    assign out_ch.total_bits = total_reg;

    a_phase_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (not_empty && head_job.has_part))
        else $error("second phase without a pending flush");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> $stable(out_byte_reg))
        else $error("held output word changed");

    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (valid_bits_reg != 4'd0 && valid_bits_reg <= BYTE_BITS))
        else $error("valid bit count out of range");

endmodule

FILE: src/pseudo_start_code_remover_top.sv
`timescale 1ns / 1ps

// Pseudo start code remover. Each input word carries one packet byte; a byte
// of value 2 that follows two zero bytes of the same packet keeps only its top
// six bits, every other byte keeps all eight, and the bits are repacked MSB
// first into output bytes. On the last byte of a packet the remaining bits are
// flushed as a zero-padded partial byte marked end_of_packet together with the
// packet's saturating bit total. The front stage takes one byte per cycle while
// the queue has room; a four-entry job queue feeds the output stage, which sends
// one word per cycle while the output is ready, so a packet end that yields both a
// full and a partial byte costs a second output word that the queue absorbs.
module pseudo_start_code_remover_top (
    input logic       clk,
    input logic       rst_n,
    psc_in_if.sink    in_ch,
    psc_out_if.source out_ch
);
    import psc_pkg::*;

    logic push;
    logic pop;
    logic not_full;
    logic not_empty;
    job_t push_job;
    job_t head_job;

    psc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_ready  (not_full),
        .push     (push),
        .push_job (push_job)
    );

    psc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .not_full  (not_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_job  (head_job)
    );

    psc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head_job  (head_job),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule
